// ===== rtl/core/rmsm_pkg.sv =====
package rmsm_pkg;

    // Field widths
    localparam int SAMPLE_FIELD_W = 10;
    localparam int ZERO_W         = 10;
    localparam int TICK_W         = 16;
    localparam int GAIN_W         = 20;
    localparam int CUR_W          = 22;
    localparam int RMS_W          = 18;
    localparam int MEAN_W         = 20;
    localparam int COUNT_W        = 24;

    // Datapath sizing
    localparam int SAMPLE_BITS   = 10;
    localparam int SUM_BITS      = 40;
    localparam int DEV_W         = (SAMPLE_BITS > ZERO_W) ? SAMPLE_BITS : ZERO_W;
    localparam int SQ_W          = 2 * DEV_W;
    localparam int MEAN_CLAMP_W  = 32;
    localparam int FRAC_W        = 16;
    localparam int RAD_W         = MEAN_CLAMP_W + FRAC_W;
    localparam int ROOT_W        = RAD_W / 2;
    localparam int RREM_W        = ROOT_W + 1;
    localparam int PROD_W        = ROOT_W + GAIN_W;
    localparam int STEP_W        = $clog2(SUM_BITS);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;

    localparam logic [ZERO_W-1:0] ZERO_OFFSET_RST  = 10'd512;
    localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 16'd20000;
    localparam logic [GAIN_W-1:0] GAIN_RST         = 20'd125123;

    // Item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_DIV       = 6'b000010,
        ST_ROOT_INIT = 6'b000100,
        ST_ROOT      = 6'b001000,
        ST_MUL       = 6'b010000,
        ST_EMIT      = 6'b100000
    } state_t;

    typedef struct packed {
        logic take_sample;
        logic take_tick;
        logic div_step;
        logic root_load;
        logic root_step;
        logic mul_load;
        logic out_load;
    } dp_cmd_t;

endpackage

// ===== rtl/core/rmsm_in_if.sv =====
interface rmsm_in_if import rmsm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [SAMPLE_FIELD_W-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

// ===== rtl/core/rmsm_out_if.sv =====
interface rmsm_out_if import rmsm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CUR_W-1:0]   current_ma;
    logic [RMS_W-1:0]   rms_q8;
    logic [MEAN_W-1:0]  mean_square;
    logic [COUNT_W-1:0] sample_count;
    logic               empty_res;
    logic               sum_saturated;

    modport source (output valid, output current_ma, output rms_q8, output mean_square,
                    output sample_count, output empty_res, output sum_saturated,
                    input ready);
    modport sink   (input valid, input current_ma, input rms_q8, input mean_square,
                    input sample_count, input empty_res, input sum_saturated,
                    output ready);
endinterface

// ===== rtl/core/rmsm_cfg_if.sv =====
interface rmsm_cfg_if import rmsm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rmsm_ctrl.sv =====
module rmsm_ctrl import rmsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rmsm_in_if.sink   meas,
    input  logic      win_end,
    input  logic      res_ready,
    output logic      res_valid,
    output dp_cmd_t   cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              res_valid_reg, res_valid_next;

    assign meas.ready = (state_reg == ST_IDLE);
    assign res_valid  = res_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        res_valid_next = res_valid_reg && !res_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (meas.valid)
                begin
                    if (meas.cmd == CMD_SAMPLE)
                    begin
                        cmd.take_sample = 1'b1;
                    end
                    else
                    begin
                        cmd.take_tick = 1'b1;
                        if (win_end)
                        begin
                            state_next = ST_DIV;
                            step_next  = STEP_W'(SUM_BITS - 1);
                        end
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_ROOT_INIT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_ROOT_INIT:
            begin
                cmd.root_load = 1'b1;
                step_next     = STEP_W'(ROOT_W - 1);
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!res_valid_reg || res_ready)
                begin
                    cmd.out_load   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== rtl/core/rmsm_datapath.sv =====
module rmsm_datapath import rmsm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    rmsm_cfg_if.sink                  cfg,
    input  logic [SAMPLE_FIELD_W-1:0] sample,
    input  dp_cmd_t                   cmd,
    output logic                      win_end,
    output logic [CUR_W-1:0]          current_ma,
    output logic [RMS_W-1:0]          rms_q8,
    output logic [MEAN_W-1:0]         mean_square,
    output logic [COUNT_W-1:0]        sample_count,
    output logic                      empty_res,
    output logic                      sum_saturated
);

    localparam logic [SUM_BITS-1:0] SUM_LIM   = {SUM_BITS{1'b1}};
    localparam logic [COUNT_W-1:0]  COUNT_LIM = {COUNT_W{1'b1}};

    // configuration
    logic [ZERO_W-1:0] zero_offset_reg, zero_offset_next;
    logic [TICK_W-1:0] window_ticks_reg, window_ticks_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;

    // window accumulation
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                sat_reg, sat_next;

    // back end
    logic [SUM_BITS-1:0] quo_reg, quo_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W-1:0]  dvs_reg, dvs_next;
    logic                snap_sat_reg, snap_sat_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [RREM_W-1:0]   rrem_reg, rrem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    // result register
    logic [CUR_W-1:0]   cur_out_reg, cur_out_next;
    logic [RMS_W-1:0]   rms_out_reg, rms_out_next;
    logic [MEAN_W-1:0]  mean_out_reg, mean_out_next;
    logic [COUNT_W-1:0] cnt_out_reg, cnt_out_next;
    logic               empty_out_reg, empty_out_next;
    logic               sat_out_reg, sat_out_next;

    logic [SAMPLE_BITS-1:0] samp;
    logic [DEV_W-1:0]       dev_a, dev_b, dev;
    logic [SQ_W-1:0]        sq;
    logic [SUM_BITS-1:0]    sq_ext, headroom;
    logic                   sat_hit;
    logic [TICK_W-1:0]      tick_inc;

    logic [COUNT_W:0]       div_sh, div_diff;
    logic                   div_fits;

    logic [SUM_BITS-1:0]     quo_upper;
    logic [MEAN_CLAMP_W-1:0] mean_cl;
    logic [RREM_W+1:0]       rt_sh, rt_trial, rt_diff;
    logic                    rt_ge;

    logic [PROD_W-FRAC_W-1:0] cur_full;
    logic                     empty_now;

    assign cfg.ready = 1'b1;

    // accumulate
    assign samp     = SAMPLE_BITS'(sample);
    assign dev_a    = DEV_W'(zero_offset_reg);
    assign dev_b    = DEV_W'(samp);
    assign dev      = (dev_a >= dev_b) ? (dev_a - dev_b) : (dev_b - dev_a);
    assign sq       = dev * dev;
    assign sq_ext   = SUM_BITS'(sq);
    assign headroom = SUM_LIM - sum_reg;
    assign sat_hit  = (sq_ext >= headroom);
    assign tick_inc = tick_reg + 1'b1;
    assign win_end  = (tick_inc >= window_ticks_reg);

    // restoring divide, one quotient bit a step
    assign div_sh   = {rem_reg, quo_reg[SUM_BITS-1]};
    assign div_fits = (div_sh >= {1'b0, dvs_reg});
    assign div_diff = div_sh - {1'b0, dvs_reg};

    // root radicand: mean clamped to 32 bits, then Q16
    assign quo_upper = quo_reg >> MEAN_CLAMP_W;
    assign mean_cl   = (|quo_upper) ? {MEAN_CLAMP_W{1'b1}} : MEAN_CLAMP_W'(quo_reg);

    // digit-by-digit root, one root bit a step
    assign rt_sh    = {rrem_reg, rad_reg[RAD_W-1 -: 2]};
    assign rt_trial = (RREM_W+2)'({root_reg, 2'b01});
    assign rt_ge    = (rt_sh >= rt_trial);
    assign rt_diff  = rt_sh - rt_trial;

    assign cur_full  = prod_reg[PROD_W-1:FRAC_W];
    assign empty_now = (dvs_reg == '0);

    always_comb
    begin
        zero_offset_next  = zero_offset_reg;
        window_ticks_next = window_ticks_reg;
        gain_next         = gain_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_ZERO_OFFSET:  zero_offset_next  = cfg.data[ZERO_W-1:0];
                REG_WINDOW_TICKS: window_ticks_next = cfg.data[TICK_W-1:0];
                REG_GAIN:         gain_next         = cfg.data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        tick_next     = tick_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        sat_next      = sat_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        snap_sat_next = snap_sat_reg;
        rad_next      = rad_reg;
        rrem_next     = rrem_reg;
        root_next     = root_reg;
        prod_next     = prod_reg;

        if (cmd.take_sample)
        begin
            if (sat_hit)
            begin
                sum_next = SUM_LIM;
                sat_next = 1'b1;
            end
            else
            begin
                sum_next = sum_reg + sq_ext;
            end
            if (count_reg != COUNT_LIM)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (cmd.take_tick)
        begin
            if (win_end)
            begin
                // hand the window to the back end and start a new one
                quo_next      = sum_reg;
                dvs_next      = count_reg;
                rem_next      = '0;
                snap_sat_next = sat_reg;
                tick_next     = '0;
                sum_next      = '0;
                count_next    = '0;
                sat_next      = 1'b0;
            end
            else
            begin
                tick_next = tick_inc;
            end
        end

        if (cmd.div_step)
        begin
            rem_next = div_fits ? div_diff[COUNT_W-1:0] : div_sh[COUNT_W-1:0];
            quo_next = {quo_reg[SUM_BITS-2:0], div_fits};
        end

        if (cmd.root_load)
        begin
            rad_next  = {mean_cl, {FRAC_W{1'b0}}};
            rrem_next = '0;
            root_next = '0;
        end

        if (cmd.root_step)
        begin
            rrem_next = rt_ge ? rt_diff[RREM_W-1:0] : rt_sh[RREM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], rt_ge};
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
        end

        if (cmd.mul_load)
        begin
            prod_next = root_reg * gain_reg;
        end
    end

    always_comb
    begin
        cur_out_next   = cur_out_reg;
        rms_out_next   = rms_out_reg;
        mean_out_next  = mean_out_reg;
        cnt_out_next   = cnt_out_reg;
        empty_out_next = empty_out_reg;
        sat_out_next   = sat_out_reg;
        if (cmd.out_load)
        begin
            cnt_out_next   = dvs_reg;
            empty_out_next = empty_now;
            sat_out_next   = snap_sat_reg;
            if (empty_now)
            begin
                cur_out_next  = '0;
                rms_out_next  = '0;
                mean_out_next = '0;
            end
            else
            begin
                cur_out_next  = (|(cur_full >> CUR_W)) ? {CUR_W{1'b1}} : CUR_W'(cur_full);
                rms_out_next  = (|(root_reg >> RMS_W)) ? {RMS_W{1'b1}} : RMS_W'(root_reg);
                mean_out_next = (|(quo_reg >> MEAN_W)) ? {MEAN_W{1'b1}} : MEAN_W'(quo_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg  <= ZERO_OFFSET_RST;
            window_ticks_reg <= WINDOW_TICKS_RST;
            gain_reg         <= GAIN_RST;
            tick_reg         <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
            sat_reg          <= 1'b0;
        end
        else
        begin
            zero_offset_reg  <= zero_offset_next;
            window_ticks_reg <= window_ticks_next;
            gain_reg         <= gain_next;
            tick_reg         <= tick_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
            sat_reg          <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        snap_sat_reg  <= snap_sat_next;
        rad_reg       <= rad_next;
        rrem_reg      <= rrem_next;
        root_reg      <= root_next;
        prod_reg      <= prod_next;
        cur_out_reg   <= cur_out_next;
        rms_out_reg   <= rms_out_next;
        mean_out_reg  <= mean_out_next;
        cnt_out_reg   <= cnt_out_next;
        empty_out_reg <= empty_out_next;
        sat_out_reg   <= sat_out_next;
    end

    assign current_ma    = cur_out_reg;
    assign rms_q8        = rms_out_reg;
    assign mean_square   = mean_out_reg;
    assign sample_count  = cnt_out_reg;
    assign empty_res     = empty_out_reg;
    assign sum_saturated = sat_out_reg;

endmodule

// ===== rtl/core/windowed_rms_current_meter_core.sv =====
// Channel  Dir  Handshake     Payload
// meas     in   valid/ready   cmd, sample
// result   out  valid/ready   current_ma, rms_q8, mean_square, sample_count,
//                             empty_res, sum_saturated
// cfg      in   valid/ready   index, data (0 zero_offset, 1 window_ticks, 2 gain)
//
// A sample or a tick that does not close the window is taken in ST_IDLE; meas.ready stays high.
// A tick that closes the window runs the restoring divider (one quotient bit a cycle),
// then the root unit (one root bit a cycle) and the gain multiply before the result
// is loaded; meas.ready stays low meanwhile.
// A finished result waits in the output register; a further window end waits
// only while that register is still full. cfg.ready is always high.
// Reset clears all counters, the sum and the handshake state; no clearing pass.
module windowed_rms_current_meter_core import rmsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rmsm_in_if.sink     meas,
    rmsm_out_if.source  result,
    rmsm_cfg_if.sink    cfg
);

    dp_cmd_t dp_cmd;
    logic    win_end;
    logic    res_valid;

    rmsm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas      (meas),
        .win_end   (win_end),
        .res_ready (result.ready),
        .res_valid (res_valid),
        .cmd       (dp_cmd)
    );

    rmsm_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .sample        (meas.sample),
        .cmd           (dp_cmd),
        .win_end       (win_end),
        .current_ma    (result.current_ma),
        .rms_q8        (result.rms_q8),
        .mean_square   (result.mean_square),
        .sample_count  (result.sample_count),
        .empty_res     (result.empty_res),
        .sum_saturated (result.sum_saturated)
    );

    assign result.valid = res_valid;

endmodule

// ===== rtl/core/rmsm_checker.sv =====
module rmsm_checker import rmsm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               valid,
    input logic               ready,
    input logic [CUR_W-1:0]   current_ma,
    input logic [RMS_W-1:0]   rms_q8,
    input logic [MEAN_W-1:0]  mean_square,
    input logic [COUNT_W-1:0] sample_count,
    input logic               empty_res,
    input logic               sum_saturated
);

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(current_ma) && $stable(rms_q8) && $stable(mean_square)
                            && $stable(sample_count) && $stable(empty_res)
                            && $stable(sum_saturated))
        else $error("result payload changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && empty_res |-> current_ma == '0 && rms_q8 == '0 && mean_square == '0
                               && sample_count == '0 && !sum_saturated)
        else $error("empty window with nonzero fields");

    a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid && sample_count == '0 |-> empty_res)
        else $error("no samples but empty flag clear");

    a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && mean_square == '0 |-> rms_q8 == '0 && current_ma == '0)
        else $error("zero mean square with nonzero root or current");

endmodule

bind windowed_rms_current_meter_core rmsm_checker u_rmsm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (result.valid),
    .ready         (result.ready),
    .current_ma    (result.current_ma),
    .rms_q8        (result.rms_q8),
    .mean_square   (result.mean_square),
    .sample_count  (result.sample_count),
    .empty_res     (result.empty_res),
    .sum_saturated (result.sum_saturated)
);
